// ===== hw/rtl/ipsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipsvc_pkg
// Shared types, codes and the sine table generator for the inverse Park /
// seven-segment SVPWM compare core.
// ----------------------------------------------------------------------------
package ipsvc_pkg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] angle;
    } in_item_t;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
        logic [2:0]  sector;
        logic        clipped;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_VOLT_D     = 2'd0,
        REG_VOLT_Q     = 2'd1,
        REG_PERIOD_TOP = 2'd2,
        REG_DUTY_GAIN  = 2'd3
    } reg_index_t;

    localparam logic [15:0] PERIOD_TOP_RESET = 16'd4199;
    localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;
    localparam logic [14:0] SINE_ONE         = 15'd32767;
    localparam logic [17:0] SQRT3_Q16        = 18'd113512;

    // sector codes from the three projection signs
    localparam logic [2:0] SEC_ZERO = 3'd0;
    localparam logic [2:0] SEC_N1   = 3'd1;
    localparam logic [2:0] SEC_N2   = 3'd2;
    localparam logic [2:0] SEC_N3   = 3'd3;
    localparam logic [2:0] SEC_N4   = 3'd4;
    localparam logic [2:0] SEC_N5   = 3'd5;
    localparam logic [2:0] SEC_N6   = 3'd6;
    // all three signs positive; cannot come out of the sign tests
    localparam logic [2:0] SEC_BAD  = 3'd7;

    // which on-times add into a phase compare (t_c always does)
    typedef struct packed {
        logic use_a;
        logic use_b;
    } term_t;

    function automatic term_t phase_term(input logic [2:0] n, input logic [1:0] ph);
        term_t t;
        t = '0;
        case (n)
            SEC_N3:  t = (ph == 2'd0) ? 2'b11 : (ph == 2'd1) ? 2'b01 : 2'b00;
            SEC_N1:  t = (ph == 2'd0) ? 2'b10 : (ph == 2'd1) ? 2'b11 : 2'b00;
            SEC_N5:  t = (ph == 2'd0) ? 2'b00 : (ph == 2'd1) ? 2'b11 : 2'b01;
            SEC_N4:  t = (ph == 2'd0) ? 2'b00 : (ph == 2'd1) ? 2'b10 : 2'b11;
            SEC_N6:  t = (ph == 2'd0) ? 2'b01 : (ph == 2'd1) ? 2'b00 : 2'b11;
            SEC_N2:  t = (ph == 2'd0) ? 2'b11 : (ph == 2'd1) ? 2'b00 : 2'b10;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Taylor series of sin(x), x in Q30, result rounded to Q15; elaboration only
    function automatic logic [14:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[14:0];
    endfunction

endpackage

// ===== hw/rtl/ipsvc_sine_rom.sv =====
// ----------------------------------------------------------------------------
// ipsvc_sine_rom
// Quarter-wave sine table, DEPTH+1 entries of Q15 magnitude, registered read.
// ----------------------------------------------------------------------------
module ipsvc_sine_rom #(
    parameter int DEPTH = 256
) (
    input  logic                         clk,
    input  logic [$clog2(DEPTH+1)-1:0]   addr,
    output logic [14:0]                  q
);
    import ipsvc_pkg::*;

    logic [14:0] tab [DEPTH+1];
    logic [14:0] q_reg;

    for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
        if (k == DEPTH) begin : g_last
            assign tab[k] = SINE_ONE;
        end else begin : g_entry
            localparam logic [63:0] X = HALF_PI_Q30 * 64'(k) / 64'(DEPTH);
            assign tab[k] = sine_entry(X);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= tab[addr];
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/inverse_park_svpwm_compare_core.sv =====
// ----------------------------------------------------------------------------
// inverse_park_svpwm_compare_core
// Angle to sin/cos, inverse Park, sector and seven-segment SVPWM compares,
// all on one shared signed multiplier under a small sequencer.
// Steps per item: the accept, the sine table reads, eight shared multiplier
// passes, rounding, on-times, three compare passes and the result load, which
// waits while a held result is stalled. The input is stalled while an item is
// in work, so a new item is taken only once the last one is through.
// Reset: asynchronous; clears sequencer, angle accumulator and result valid,
// and returns the config regs to their defaults.
// ----------------------------------------------------------------------------
module inverse_park_svpwm_compare_core #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  ipsvc_pkg::in_item_t  cmd_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output ipsvc_pkg::out_item_t res_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ipsvc_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SIN   = 11'b00000000010,
        S_COS   = 11'b00000000100,
        S_CAP   = 11'b00000001000,
        S_PROD  = 11'b00000010000,
        S_PMUL  = 11'b00000100000,
        S_ROUND = 11'b00001000000,
        S_GAIN  = 11'b00010000000,
        S_TIMES = 11'b00100000000,
        S_SAT   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    // configuration
    logic signed [15:0] volt_d_reg, volt_q_reg;
    logic [15:0]        period_top_reg;
    logic [23:0]        duty_gain_reg;
    logic               cfg_wr;
    reg_index_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_d_reg     <= '0;
            volt_q_reg     <= '0;
            period_top_reg <= PERIOD_TOP_RESET;
            duty_gain_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_VOLT_D:     volt_d_reg     <= pwdata[15:0];
                REG_VOLT_Q:     volt_q_reg     <= pwdata[15:0];
                REG_PERIOD_TOP: period_top_reg <= pwdata[15:0];
                REG_DUTY_GAIN:  duty_gain_reg  <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_VOLT_D:     prdata = {16'd0, volt_d_reg};
            REG_VOLT_Q:     prdata = {16'd0, volt_q_reg};
            REG_PERIOD_TOP: prdata = {16'd0, period_top_reg};
            REG_DUTY_GAIN:  prdata = {8'd0, duty_gain_reg};
            default:        prdata = '0;
        endcase
    end

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [15:0]         angle_accum_reg;
    logic [15:0]         ang_reg;
    logic                rom_neg_reg;
    logic signed [15:0]  sin_reg, cos_reg;
    logic signed [32:0]  alpha_reg, beta_reg;
    logic signed [51:0]  p_reg;
    logic [2:0]          sector_reg;
    logic signed [30:0]  r_reg [3];
    logic signed [55:0]  g_reg [3];
    logic signed [63:0]  ta_reg, tb_reg, tc_reg;
    logic [15:0]         cmp_reg [3];
    logic                clip_reg;
    logic                res_valid_reg;
    out_item_t           res_data_reg;

    logic cmd_xfer, res_xfer;
    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_xfer  = cmd_valid & ~cmd_stall;
    assign res_xfer  = res_valid_reg & ~res_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // sine table lookup
    logic [15:0]     rom_ang;
    logic [13+AW:0]  rom_scaled;
    logic [AW-1:0]   rom_idx, rom_addr;
    logic [14:0]     rom_q;
    logic signed [15:0] rom_val;

    assign rom_ang    = (state_reg == S_COS) ? ang_reg + 16'd16384 : ang_reg;
    assign rom_scaled = {{AW{1'b0}}, rom_ang[13:0]} * (14 + AW)'(SINE_TABLE_DEPTH);
    assign rom_idx    = rom_scaled[13+AW:14];
    assign rom_addr   = rom_ang[14] ? AW'(SINE_TABLE_DEPTH) - rom_idx : rom_idx;
    assign rom_val    = rom_neg_reg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

    ipsvc_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [58:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PROD:
            begin
                mul_a = (cnt_reg[0]) ? 34'(volt_q_reg) : 34'(volt_d_reg);
                case (cnt_reg)
                    2'd0:    mul_b = 25'(cos_reg);
                    2'd1:    mul_b = 25'(sin_reg);
                    2'd2:    mul_b = 25'(sin_reg);
                    default: mul_b = 25'(cos_reg);
                endcase
            end
            S_PMUL:
            begin
                mul_a = 34'(alpha_reg);
                mul_b = $signed({7'd0, SQRT3_Q16});
            end
            S_GAIN:
            begin
                mul_a = 34'(r_reg[cnt_reg]);
                mul_b = $signed({1'b0, duty_gain_reg});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // projections 2A, 2B, 2C in Q31 and their Q8 rounding
    logic signed [53:0] bx, bh, proj_x, proj_y, proj_z;
    assign bx     = 54'(beta_reg) <<< 17;
    assign bh     = 54'(beta_reg) <<< 16;
    assign proj_x = bx;
    assign proj_y = 54'(p_reg) - bh;
    assign proj_z = -54'(p_reg) - bh;

    function automatic logic signed [30:0] rnd23(input logic signed [53:0] v);
        logic signed [53:0] t;
        t = (v + 54'sd4194304) >>> 23;
        return t[30:0];
    endfunction

    // on-times per sector
    logic signed [63:0] ta_sel, tb_sel, tc_calc;
    always_comb
    begin
        case (sector_reg)
            SEC_N3:  begin ta_sel =  64'(g_reg[1]); tb_sel =  64'(g_reg[0]); end
            SEC_N1:  begin ta_sel = -64'(g_reg[2]); tb_sel = -64'(g_reg[1]); end
            SEC_N5:  begin ta_sel =  64'(g_reg[0]); tb_sel =  64'(g_reg[2]); end
            SEC_N4:  begin ta_sel = -64'(g_reg[1]); tb_sel = -64'(g_reg[0]); end
            SEC_N6:  begin ta_sel =  64'(g_reg[2]); tb_sel =  64'(g_reg[1]); end
            SEC_N2:  begin ta_sel = -64'(g_reg[0]); tb_sel = -64'(g_reg[2]); end
            default: begin ta_sel = '0;             tb_sel = '0;             end
        endcase
        tc_calc = ($signed({48'd0, period_top_reg}) <<< 25) - ta_sel - tb_sel;
    end

    // per-phase sum, round and saturate; a zero vector gives half the period
    term_t              term;
    logic signed [63:0] phase_sum, phase_rnd;
    logic [15:0]        phase_cmp;
    logic               phase_clip, zero_vec;

    assign term      = phase_term(sector_reg, cnt_reg);
    assign zero_vec  = (sector_reg == SEC_ZERO) || (sector_reg == SEC_BAD);
    assign phase_sum = tc_reg + (term.use_a ? ta_reg : 64'sd0) + (term.use_b ? tb_reg : 64'sd0);
    assign phase_rnd = (phase_sum + 64'sd33554432) >>> 26;

    always_comb
    begin
        phase_clip = 1'b0;
        if (zero_vec)
            phase_cmp = period_top_reg >> 1;
        else if (phase_rnd < 0)
        begin
            phase_cmp  = '0;
            phase_clip = 1'b1;
        end
        else if (phase_rnd > $signed({48'd0, period_top_reg}))
        begin
            phase_cmp  = period_top_reg;
            phase_clip = 1'b1;
        end
        else
            phase_cmp = phase_rnd[15:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:  if (cmd_xfer) state_next = S_SIN;
            S_SIN:   state_next = S_COS;
            S_COS:   state_next = S_CAP;
            S_CAP:   begin state_next = S_PROD; cnt_next = '0; end
            S_PROD:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_PMUL;
            end
            S_PMUL:  state_next = S_ROUND;
            S_ROUND: begin state_next = S_GAIN; cnt_next = '0; end
            S_GAIN:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                    state_next = S_TIMES;
            end
            S_TIMES: begin state_next = S_SAT; cnt_next = '0; end
            S_SAT:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                    state_next = S_DONE;
            end
            S_DONE:  if (!res_valid_reg || !res_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            angle_accum_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cmd_xfer && cmd_data.cmd)
                angle_accum_reg <= angle_accum_reg + cmd_data.angle;
            if (state_reg == S_DONE && (!res_valid_reg || !res_stall))
                res_valid_reg <= 1'b1;
            else if (res_xfer)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
            ang_reg <= cmd_data.cmd ? angle_accum_reg + cmd_data.angle : cmd_data.angle;
        rom_neg_reg <= rom_ang[15];
        case (state_reg)
            S_COS: sin_reg <= rom_val;
            S_CAP: cos_reg <= rom_val;
            S_PROD:
            begin
                case (cnt_reg)
                    2'd0:    alpha_reg <= mul_p[32:0];
                    2'd1:    alpha_reg <= alpha_reg - mul_p[32:0];
                    2'd2:    beta_reg  <= mul_p[32:0];
                    default: beta_reg  <= beta_reg + mul_p[32:0];
                endcase
            end
            S_PMUL: p_reg <= mul_p[51:0];
            S_ROUND:
            begin
                r_reg[0]   <= rnd23(proj_x);
                r_reg[1]   <= rnd23(proj_y);
                r_reg[2]   <= rnd23(proj_z);
                sector_reg <= {proj_z > 0, proj_y > 0, proj_x > 0};
            end
            S_GAIN: g_reg[cnt_reg] <= mul_p[55:0];
            S_TIMES:
            begin
                ta_reg   <= ta_sel <<< 1;
                tb_reg   <= tb_sel <<< 1;
                tc_reg   <= tc_calc;
                clip_reg <= 1'b0;
            end
            S_SAT:
            begin
                cmp_reg[cnt_reg] <= phase_cmp;
                clip_reg         <= clip_reg | phase_clip;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_data_reg.compare_a <= cmp_reg[0];
                    res_data_reg.compare_b <= cmp_reg[1];
                    res_data_reg.compare_c <= cmp_reg[2];
                    res_data_reg.sector    <= sector_reg;
                    res_data_reg.clipped   <= clip_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> state_reg == S_SIN)
        else $error("transfer did not start the sequencer");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == S_DONE))
        else $error("result valid without finishing an item");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.clipped && res_data.sector == SEC_ZERO))
        else $error("zero vector reported clipping");
`endif

endmodule
